### rtl/dsq_pkg.sv
// Package for the date sorted queue: field widths, codes and the cell types.
// No dependencies; every other file of the block uses it.
package dsq_pkg;

  localparam int KEY_W = 21;
  localparam int TAG_W = 16;
  localparam int DEFAULT_CAPACITY = 16;
  localparam int COUNT_W = 5;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cmd_t;

endpackage

### rtl/dsq_cell.sv
// One cell of the sorted row: holds a single entry and moves it on insert or remove.
// Depends on dsq_pkg.
module dsq_cell (
  input  logic          clk,
  input  logic          rst,
  input  dsq_pkg::cmd_t  cmd,
  input  dsq_pkg::cell_t left,
  input  logic          left_cond,
  input  dsq_pkg::cell_t right,
  output dsq_pkg::cell_t state,
  output logic          cond
);

  // The new key belongs at or before this cell when the cell is empty or not earlier.
  assign cond = !state.valid || (state.key >= cmd.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.valid <= 1'b0;
    end else if (cmd.ins) begin
      if (left_cond) begin
        state <= left;
      end else if (cond) begin
        state.valid <= 1'b1;
        state.key <= cmd.key;
        state.tag <= cmd.tag;
      end
    end else if (cmd.rem) begin
      state <= right;
    end
  end

endmodule

### rtl/date_sorted_queue.sv
// Top level of the date sorted queue: stream ports, head match, count and result word.
// Depends on dsq_pkg and dsq_cell.
//
// Channel  Dir  Fields (low bit up)
// s        in   tuser: operation; tdata: day, month, year, tag, zero pad to 40
// m        out  tuser: status; tdata: count, removed_tag, zero pad to 24
//
// The whole row of cells shifts in the cycle a word is accepted, so the next word can follow without a gap.
// The result word sits in an output register; a new word is accepted when it is empty or taken.
// Reset empties every cell and the count at once.
// A stalled output holds the input off until the result is taken.
module date_sorted_queue #(
  parameter int CAPACITY = dsq_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // day[4:0], month[8:5], year[20:9], tag[36:21]
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // count[4:0], removed_tag[20:5]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dsq_pkg::cmd_t                    cmd;
  dsq_pkg::cell_t                   cells [CAPACITY];
  logic [CAPACITY-1:0]             conds;
  logic [CAPACITY-1:0]             valids;
  logic [CNT_W-1:0]                count;
  logic [dsq_pkg::STATUS_W-1:0]    status;
  logic [dsq_pkg::TAG_W-1:0]       removed_tag;
  logic                            accept;
  logic                            full;
  logic                            head_match;
  logic [dsq_pkg::KEY_W-1:0]       in_key;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;
  assign in_key = s_tdata[20:0];
  assign full = (count == CNT_W'(CAPACITY));
  assign head_match = cells[0].valid && (cells[0].key == in_key);

  assign cmd.ins = accept && (s_tuser[0] == dsq_pkg::OP_INSERT) && !full;
  assign cmd.rem = accept && (s_tuser[0] == dsq_pkg::OP_REMOVE) && head_match;
  assign cmd.key = in_key;
  assign cmd.tag = s_tdata[36:21];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dsq_pkg::cell_t left;
    dsq_pkg::cell_t right;
    logic           left_cond;
    if (i == 0) begin : g_head
      assign left = '0;
      assign left_cond = 1'b0;
    end else begin : g_body
      assign left = cells[i-1];
      assign left_cond = conds[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cells[i+1];
    end
    dsq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left      (left),
      .left_cond (left_cond),
      .right     (right),
      .state     (cells[i]),
      .cond      (conds[i])
    );
    assign valids[i] = cells[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        m_tvalid <= 1'b1;
        removed_tag <= '0;
        if (s_tuser[0] == dsq_pkg::OP_INSERT) begin
          if (full) begin
            status <= dsq_pkg::ST_FULL;
          end else begin
            status <= dsq_pkg::ST_INSERTED;
            count <= count + CNT_W'(1);
          end
        end else if (head_match) begin
          status <= dsq_pkg::ST_REMOVED;
          removed_tag <= cells[0].tag;
          count <= count - CNT_W'(1);
        end else begin
          status <= dsq_pkg::ST_NOMATCH;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = status;
  assign m_tdata = {3'b000, removed_tag, dsq_pkg::COUNT_W'(count)};

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == int'(count))
    else $error("count differs from occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((valids >> 1) & ~valids) == '0)
    else $error("occupied cells are not packed at the head");

  a_tag_only_on_remove: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status != dsq_pkg::ST_REMOVED) |-> removed_tag == '0)
    else $error("removed tag set without a removal");

  a_head_ordered: assert property (@(posedge clk) disable iff (rst)
    (CAPACITY > 1) && valids[CAPACITY > 1 ? 1 : 0] |-> cells[0].key <= cells[CAPACITY > 1 ? 1 : 0].key)
    else $error("head entry later than its successor");

endmodule

### test/date_sorted_queue_tb.sv
// Testbench for the date sorted queue: directed date corners, fill and overflow,
// output back-pressure and random insert/remove traffic, checked against a predictor.
// Depends on dsq_pkg and date_sorted_queue.
`timescale 1ns / 100ps

module date_sorted_queue_tb;

  localparam int CAPACITY = dsq_pkg::DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [dsq_pkg::STATUS_W-1:0] status;
    logic [dsq_pkg::COUNT_W-1:0]  count;
    logic [dsq_pkg::TAG_W-1:0]    removed_tag;
  } queue_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  logic [dsq_pkg::KEY_W-1:0] held_keys [CAPACITY];
  logic [dsq_pkg::TAG_W-1:0] held_tags [CAPACITY];
  int                        held_count;
  queue_result_t             pending_results [$];
  logic [dsq_pkg::KEY_W-1:0] date_pool [6];

  int error_count;
  int cycle_count;
  bit tx_idle;
  bit rx_idle;
  bit hold_request;
  int hold_left;
  int stall_left;

  date_sorted_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [dsq_pkg::KEY_W-1:0] make_date(input int year, input int month,
                                                          input int day);
    return {year[11:0], month[3:0], day[4:0]};
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one word to the predicted queue and returns the result it should produce.
  function automatic queue_result_t queue_apply(input logic op,
                                                input logic [dsq_pkg::KEY_W-1:0] key,
                                                input logic [dsq_pkg::TAG_W-1:0] tag);
    queue_result_t res;
    int pos;
    res = '0;
    if (op == dsq_pkg::OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = dsq_pkg::ST_FULL;
      end else begin
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_keys[i] >= key) pos = i;
        end
        for (int i = held_count; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_tags[i] = held_tags[i-1];
        end
        held_keys[pos] = key;
        held_tags[pos] = tag;
        held_count++;
        res.status = dsq_pkg::ST_INSERTED;
      end
    end else begin
      if (held_count == 0 || held_keys[0] != key) begin
        res.status = dsq_pkg::ST_NOMATCH;
      end else begin
        res.removed_tag = held_tags[0];
        for (int i = 1; i < held_count; i++) begin
          held_keys[i-1] = held_keys[i];
          held_tags[i-1] = held_tags[i];
        end
        held_count--;
        res.status = dsq_pkg::ST_REMOVED;
      end
    end
    res.count = held_count[dsq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Offers one word and returns once it is taken and any idle gap has passed; valid stays high
  // when no gap follows, so back-to-back words keep the stream busy.
  task automatic send_word(input logic op, input logic [dsq_pkg::KEY_W-1:0] key,
                           input logic [dsq_pkg::TAG_W-1:0] tag);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, tag, key};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(queue_apply(op, key, tag));
    gap = tx_idle ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [dsq_pkg::KEY_W-1:0] pick_date();
    if ($urandom_range(0, 1) == 0) return date_pool[$urandom_range(0, 5)];
    return dsq_pkg::KEY_W'($urandom());
  endfunction

  task automatic test_corner_dates();
    logic [dsq_pkg::KEY_W-1:0] lo_date;
    logic [dsq_pkg::KEY_W-1:0] hi_date;
    lo_date = make_date(0, 0, 0);
    hi_date = make_date(4095, 15, 31);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word(dsq_pkg::OP_REMOVE, lo_date, 16'h0000);
    send_word(dsq_pkg::OP_INSERT, hi_date, 16'h1234);
    send_word(dsq_pkg::OP_INSERT, lo_date, 16'hFFFF);
    // An equal date goes ahead of the one already stored.
    send_word(dsq_pkg::OP_INSERT, lo_date, 16'h0001);
    // Only the head is examined, so a date further back does not match.
    send_word(dsq_pkg::OP_REMOVE, hi_date, 16'h0000);
    send_word(dsq_pkg::OP_REMOVE, lo_date, 16'hFFFF);
    send_word(dsq_pkg::OP_REMOVE, lo_date, 16'h0000);
    send_word(dsq_pkg::OP_REMOVE, hi_date, 16'hABCD);
    wait_drained();
  endtask

  task automatic test_fill_and_overflow();
    for (int i = 0; i < CAPACITY; i++) begin
      send_word(dsq_pkg::OP_INSERT, pick_date(), 16'($urandom()));
    end
    send_word(dsq_pkg::OP_INSERT, make_date(2000, 6, 15), 16'h5A5A);
    wait_drained();
  endtask

  // The receiver stops for a long stretch while words keep coming back to back.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (held_count > 0 && $urandom_range(0, 1) == 0) begin
        send_word(dsq_pkg::OP_REMOVE, held_keys[0], 16'($urandom()));
      end else begin
        send_word(dsq_pkg::OP_INSERT, pick_date(), 16'($urandom()));
      end
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int insert_pct;
    logic op;
    logic [dsq_pkg::KEY_W-1:0] key;
    for (int seg = 0; seg < 13; seg++) begin
      insert_pct = (seg % 2 == 0) ? 75 : 30;
      tx_idle = (seg % 4 != 3);
      rx_idle = (seg % 5 != 4);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          op  = 1'($urandom());
          key = dsq_pkg::KEY_W'($urandom());
        end else begin
          op = ($urandom_range(0, 99) < insert_pct) ? dsq_pkg::OP_INSERT : dsq_pkg::OP_REMOVE;
          if (op == dsq_pkg::OP_REMOVE && held_count > 0 && $urandom_range(0, 3) != 0) begin
            key = held_keys[0];
          end else begin
            key = pick_date();
          end
        end
        send_word(op, key, 16'($urandom()));
      end
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = rx_idle ? idle_len() : 0;
      m_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %h/%h", m_tuser, m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
        if (m_tdata[4:0] != want.count)
          report_mismatch($sformatf("count %0d, expected %0d", m_tdata[4:0], want.count));
        if (m_tdata[20:5] != want.removed_tag)
          report_mismatch($sformatf("removed_tag %h, expected %h", m_tdata[20:5],
                                    want.removed_tag));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    held_count = 0;
    error_count = 0;
    cycle_count = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 1'b0;
    hold_left = 0;
    stall_left = 0;
    for (int i = 0; i < 6; i++) date_pool[i] = dsq_pkg::KEY_W'($urandom());
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_dates();
    test_fill_and_overflow();
    test_backpressure();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### date_sorted_queue.f
rtl/dsq_pkg.sv
rtl/dsq_cell.sv
rtl/date_sorted_queue.sv
test/date_sorted_queue_tb.sv
